[src/potb_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// potb_pkg: shared types and constants for the periodic / one-shot timer bank
// Holds the bank size, item kinds, sequencer states and flag packing helper.
// ---------------------------------------------------------------------------
package potb_pkg;

  // Bank size and derived widths
  localparam int TIMER_COUNT = 8;
  localparam int IDX_W       = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
  localparam int TICK_W      = 32;
  localparam int FLAG_W      = 8;
  localparam int ENTRY_W     = 2 * TICK_W;

  // Item kinds
  typedef enum logic [2:0] {
    KIND_TICK    = 3'd0,
    KIND_RESTART = 3'd1,
    KIND_ONESHOT = 3'd2,
    KIND_CLEAR   = 3'd3,
    KIND_PERIOD  = 3'd4,
    KIND_DISABLE = 3'd5
  } kind_t;

  // Sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_PER_WR,
    ST_DONE
  } state_t;

  // Pack per-timer flags into the fixed 8-bit result field;
  // timers that do not exist read as zero.
  function automatic logic [FLAG_W-1:0] pack_flags(input logic [TIMER_COUNT-1:0] f);
    logic [FLAG_W-1:0] bits;
    bits = '0;
    for (int i = 0; i < FLAG_W; i++) begin
      if (i < TIMER_COUNT) begin
        bits[i] = f[i];
      end
    end
    return bits;
  endfunction

endpackage

[src/periodic_one_shot_timer_bank.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// periodic_one_shot_timer_bank: bank of tick-driven periodic/one-shot timers
// Start times and periods live in one synchronous RAM; flags in flip-flops.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall): one item = kind, timer_index, amount.
//   Result channel (out_valid / out_stall): exactly one item per input item,
//   carrying the expired flags, running flags and the tick count after it.
//   Steps per kind:
//     tick, restart : one read-modify-write pass over the RAM, one timer per
//                     cycle, then the result register.
//     set period    : RAM read then write back, then the result register.
//     arm, clear, disable, unused kinds : straight to the result register.
//   The single RAM port pair and the per-timer scan shape these steps; one
//   item is in work at a time, in_stall is high while it is.
//   Reset clears the tick count, all flags and the per-entry valid bits, so
//   unwritten RAM entries read as zero start and zero period. No clearing pass.
//   A stalled result stays in the output register; the block still accepts
//   and works the next item, holding its result until the register frees.
// ---------------------------------------------------------------------------
module periodic_one_shot_timer_bank (
  input  logic        clk,
  input  logic        rst_n,
  // input items
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_kind,
  input  logic [2:0]  in_timer_index,
  input  logic [31:0] in_amount,
  // result items
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_elapsed_flags,
  output logic [7:0]  out_enabled_flags,
  output logic [31:0] out_tick_now
);

  localparam int                  NT   = potb_pkg::TIMER_COUNT;
  localparam int                  IW   = potb_pkg::IDX_W;
  localparam int                  TW   = potb_pkg::TICK_W;
  localparam int                  EW   = potb_pkg::ENTRY_W;
  localparam logic [IW-1:0]       LAST = IW'(NT - 1);

  // Control registers
  potb_pkg::state_t state_r, state_nxt;
  logic [IW-1:0]    cnt_r, cnt_nxt;
  logic             restart_r, restart_nxt;
  logic [TW-1:0]    tick_r, tick_nxt;
  logic [NT-1:0]    running_r, running_nxt;
  logic [NT-1:0]    repeating_r, repeating_nxt;
  logic [NT-1:0]    expired_r, expired_nxt;
  logic [NT-1:0]    vld_r, vld_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             rd_vld_r;

  // Payload registers
  logic [IW-1:0]    idx_r, idx_nxt;
  logic [TW-1:0]    amount_r, amount_nxt;
  logic [7:0]       elapsed_r, elapsed_nxt;
  logic [7:0]       enabled_r, enabled_nxt;
  logic [TW-1:0]    tick_now_r, tick_now_nxt;

  // Entry RAM: {start_time, period_length}
  logic [EW-1:0]    mem [NT];
  logic [EW-1:0]    mem_q;
  logic             mem_we, mem_re;
  logic [IW-1:0]    mem_wa, mem_ra;
  logic [EW-1:0]    mem_wd;

  logic [TW-1:0]    ent_start, ent_period, ent_age;
  logic [IW-1:0]    in_idx;
  logic             idx_ok;
  logic             due;

  // RAM with registered read data
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (mem_re) begin
      mem_q    <= mem[mem_ra];
      rd_vld_r <= vld_r[mem_ra];
    end
  end

  // Never-written entries read as zero
  assign ent_start  = rd_vld_r ? mem_q[EW-1:TW] : '0;
  assign ent_period = rd_vld_r ? mem_q[TW-1:0]  : '0;
  assign ent_age    = tick_r - ent_start;
  assign due        = running_r[cnt_r] && (ent_age >= ent_period);

  assign in_idx = IW'(in_timer_index);
  assign idx_ok = (32'(in_timer_index) < 32'(NT));

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    restart_nxt   = restart_r;
    tick_nxt      = tick_r;
    running_nxt   = running_r;
    repeating_nxt = repeating_r;
    expired_nxt   = expired_r;
    vld_nxt       = vld_r;
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    amount_nxt    = amount_r;
    elapsed_nxt   = elapsed_r;
    enabled_nxt   = enabled_r;
    tick_now_nxt  = tick_now_r;
    mem_we        = 1'b0;
    mem_re        = 1'b0;
    mem_wa        = cnt_r;
    mem_ra        = '0;
    mem_wd        = mem_q;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      potb_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = potb_pkg::ST_DONE;
          case (potb_pkg::kind_t'(in_kind))
            potb_pkg::KIND_TICK: begin
              tick_nxt    = tick_r + 1'b1;
              restart_nxt = 1'b0;
              cnt_nxt     = '0;
              mem_re      = 1'b1;
              state_nxt   = potb_pkg::ST_SCAN;
            end
            potb_pkg::KIND_RESTART: begin
              running_nxt   = '1;
              repeating_nxt = '1;
              restart_nxt   = 1'b1;
              cnt_nxt       = '0;
              mem_re        = 1'b1;
              state_nxt     = potb_pkg::ST_SCAN;
            end
            potb_pkg::KIND_ONESHOT: begin
              if (idx_ok) begin
                mem_we                = 1'b1;
                mem_wa                = in_idx;
                mem_wd                = {tick_r, in_amount};
                vld_nxt[in_idx]       = 1'b1;
                repeating_nxt[in_idx] = 1'b0;
                running_nxt[in_idx]   = 1'b1;
              end
            end
            potb_pkg::KIND_CLEAR: begin
              if (idx_ok) begin
                expired_nxt[in_idx] = 1'b0;
              end
            end
            potb_pkg::KIND_PERIOD: begin
              if (idx_ok) begin
                mem_re     = 1'b1;
                mem_ra     = in_idx;
                idx_nxt    = in_idx;
                amount_nxt = in_amount;
                state_nxt  = potb_pkg::ST_PER_WR;
              end
            end
            potb_pkg::KIND_DISABLE: begin
              if (idx_ok) begin
                running_nxt[in_idx] = 1'b0;
              end
            end
            default: begin
            end
          endcase
        end
      end

      // one entry per cycle: write back entry cnt, read entry cnt+1
      potb_pkg::ST_SCAN: begin
        mem_we         = 1'b1;
        mem_wa         = cnt_r;
        vld_nxt[cnt_r] = 1'b1;
        if (restart_r) begin
          mem_wd = {tick_r, ent_period};
        end else begin
          mem_wd = {ent_start, ent_period};
          if (due) begin
            expired_nxt[cnt_r] = 1'b1;
            if (repeating_r[cnt_r]) begin
              mem_wd = {ent_start + ent_period, ent_period};
            end else begin
              running_nxt[cnt_r] = 1'b0;
            end
          end
        end
        if (cnt_r == LAST) begin
          state_nxt = potb_pkg::ST_DONE;
        end else begin
          mem_re  = 1'b1;
          mem_ra  = cnt_r + 1'b1;
          cnt_nxt = cnt_r + 1'b1;
        end
      end

      // set period: keep start, replace period
      potb_pkg::ST_PER_WR: begin
        mem_we         = 1'b1;
        mem_wa         = idx_r;
        mem_wd         = {ent_start, amount_r};
        vld_nxt[idx_r] = 1'b1;
        state_nxt      = potb_pkg::ST_DONE;
      end

      // load result register once it is free
      potb_pkg::ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          elapsed_nxt   = potb_pkg::pack_flags(expired_r);
          enabled_nxt   = potb_pkg::pack_flags(running_r);
          tick_now_nxt  = tick_r;
          state_nxt     = potb_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = potb_pkg::ST_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= potb_pkg::ST_IDLE;
      cnt_r       <= '0;
      restart_r   <= 1'b0;
      tick_r      <= '0;
      running_r   <= '0;
      repeating_r <= '0;
      expired_r   <= '0;
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      restart_r   <= restart_nxt;
      tick_r      <= tick_nxt;
      running_r   <= running_nxt;
      repeating_r <= repeating_nxt;
      expired_r   <= expired_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    idx_r      <= idx_nxt;
    amount_r   <= amount_nxt;
    elapsed_r  <= elapsed_nxt;
    enabled_r  <= enabled_nxt;
    tick_now_r <= tick_now_nxt;
  end

  assign in_stall          = (state_r != potb_pkg::ST_IDLE);
  assign out_valid         = out_valid_r;
  assign out_elapsed_flags = elapsed_r;
  assign out_enabled_flags = enabled_r;
  assign out_tick_now      = tick_now_r;

endmodule
